// ===== sv/psc_pkg.sv =====
// Shared types, widths and codes for the point-to-segment closest point block.
// Used by every module of the block; depends on nothing.
package psc_pkg;

    localparam int COORD_W     = 16;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int DOT_W       = PROD_W + 1;
    localparam int L2_W        = PROD_W;
    localparam int PPLO_W      = 35;
    localparam int PPHI_W      = 34;
    localparam int NUM_W       = 52;
    localparam int QUOT_W      = 19;
    localparam int CAND_W      = 21;
    localparam int THRESH_W    = 16;
    localparam int SLOPE_W     = 32;
    localparam int SNUM_W      = DIFF_W + 16;
    localparam int SDEN_W      = DIFF_W;
    localparam int SQUOT_W     = SNUM_W + 1;
    localparam int SDIV_W      = SDEN_W + SQUOT_W;
    localparam int RAD_W       = 34;
    localparam int ROOT_W      = 17;
    localparam int SQ_WORK_W   = RAD_W + 1;
    localparam int DIV_LAT     = QUOT_W;
    localparam int SQRT_LAT    = ROOT_W;
    localparam int PIPE_DEPTH  = 5 + DIV_LAT + 4 + SQRT_LAT;
    localparam int CFG_IDX_W   = 3;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 136;

    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 3'd4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;

    typedef enum logic [1:0] {
        SEL_LINE,
        SEL_START,
        SEL_END
    } proj_sel_t;

    // Sideband that rides along the projection divider.
    typedef struct packed {
        coord_t    px;
        coord_t    py;
        logic      neg_x;
        logic      neg_y;
        proj_sel_t sel;
        logic      degen;
    } side_t;

    // Sideband that rides along the distance square root.
    typedef struct packed {
        coord_t cx;
        coord_t cy;
        logic   degen;
    } tail_t;

    function automatic coord_t sat_coord(input logic signed [CAND_W-1:0] v);
        coord_t r;
        if (v > CAND_W'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -CAND_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/point_segment_closest_distance_top.sv =====
// Top level of the closest point on a 2D segment block.
// Depends on psc_pkg, psc_isqrt, psc_proj_div and psc_slope_div.
//
// The segment endpoints and the flat threshold are written over the cfg channel
// (index 0 start_x, 1 start_y, 2 end_x, 3 end_y, 4 flat_threshold); cfg_ready is
// always high and writes to other indexes are dropped. Writes are expected only
// while no query is in flight.
// Each word on the s_ channel is one query point; each word on the m_ channel is
// its result: the projection onto the segment line (clamped if asked), the
// distance to it, and the segment midpoint, slope and length.
// One query is taken per cycle while s_tready is high. A query passes through every
// pipeline stage and then the output register before it shows on m_tvalid; the
// depth is set mostly by the 19-stage projection divider and the 17-stage
// square root in series.
// Slope and length are derived from the registers by a free-running divider and
// square root that settle again after each write.
// Reset clears the registers to their defaults and empties the pipeline.
// When the receiver stalls, the pipeline keeps moving until a result reaches
// its last stage behind the waiting output word; only then does s_tready drop.
module point_segment_closest_distance_top import psc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // point_x [15:0], point_y [31:16]
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // clamp_to_segment [0]
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // closest_x [15:0], closest_y [31:16], point_distance [48:32], mid_x [64:49],
    // mid_y [80:65], slope_value [112:81], segment_length [129:113], zeros above
    output logic [TDATA_OUT_W-1:0] m_tdata,
    // degenerate [0]
    output logic                   m_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_W-1:0]     cfg_data
);

    localparam int LAST = PIPE_DEPTH - 1;

    // Configuration registers.
    coord_t              start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [THRESH_W-1:0] thresh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            thresh_reg  <= THRESH_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_START_X: start_x_reg <= cfg_data;
                REG_START_Y: start_y_reg <= cfg_data;
                REG_END_X:   end_x_reg   <= cfg_data;
                REG_END_Y:   end_y_reg   <= cfg_data;
                REG_THRESH:  thresh_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together unless a finished result sits in the
    // last stage while the output word is still waiting.
    logic en;
    logic vld_reg [0:LAST];
    logic m_tvalid_reg;

    assign en       = !(vld_reg[LAST] && m_tvalid_reg && !m_tready);
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Stage 1: offsets from the start point.
    coord_t in_px, in_py;
    diff_t  s1_vx_reg, s1_vy_reg, s1_dx_reg, s1_dy_reg;
    coord_t s1_px_reg, s1_py_reg;
    logic   s1_clamp_reg;

    assign in_px = s_tdata[COORD_W-1:0];
    assign in_py = s_tdata[2*COORD_W-1:COORD_W];

    // Stage 2: products.
    logic signed [PROD_W-1:0] s2_pvx_reg, s2_pvy_reg, s2_ddx_reg, s2_ddy_reg;
    diff_t                    s2_dx_reg, s2_dy_reg;
    coord_t                   s2_px_reg, s2_py_reg;
    logic                     s2_clamp_reg;

    // Stage 3: dot product and squared length.
    logic signed [DOT_W-1:0] s3_dot_reg;
    logic [L2_W-1:0]         s3_l2_reg;
    diff_t                   s3_dx_reg, s3_dy_reg;
    coord_t                  s3_px_reg, s3_py_reg;
    logic                    s3_clamp_reg;

    // Stage 4: magnitudes, partial products of d * dot, case selection.
    logic              dot_neg;
    logic [DOT_W-1:0]  dot_mag;
    logic [DIFF_W-1:0] adx, ady;
    proj_sel_t         sel_next;
    logic              degen_next;
    logic [PPLO_W-1:0] s4_ppx_lo_reg, s4_ppy_lo_reg;
    logic [PPHI_W-1:0] s4_ppx_hi_reg, s4_ppy_hi_reg;
    logic [L2_W-1:0]   s4_l2_reg;
    side_t             s4_side_reg;

    assign dot_neg = s3_dot_reg[DOT_W-1];
    assign dot_mag = dot_neg ? DOT_W'(-s3_dot_reg) : DOT_W'(s3_dot_reg);
    assign adx     = s3_dx_reg[DIFF_W-1] ? DIFF_W'(-s3_dx_reg) : DIFF_W'(s3_dx_reg);
    assign ady     = s3_dy_reg[DIFF_W-1] ? DIFF_W'(-s3_dy_reg) : DIFF_W'(s3_dy_reg);

    always_comb begin
        degen_next = (s3_l2_reg == '0);
        if (degen_next || (s3_clamp_reg && dot_neg)) begin
            sel_next = SEL_START;
        end else if (s3_clamp_reg && (s3_dot_reg > $signed({1'b0, s3_l2_reg}))) begin
            sel_next = SEL_END;
        end else begin
            sel_next = SEL_LINE;
        end
    end

    // Stage 5: full numerators.
    logic [NUM_W-1:0] s5_numx_reg, s5_numy_reg;
    logic [L2_W-1:0]  s5_l2_reg;
    side_t            s5_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_vx_reg    <= DIFF_W'(in_px) - DIFF_W'(start_x_reg);
            s1_vy_reg    <= DIFF_W'(in_py) - DIFF_W'(start_y_reg);
            s1_dx_reg    <= DIFF_W'(end_x_reg) - DIFF_W'(start_x_reg);
            s1_dy_reg    <= DIFF_W'(end_y_reg) - DIFF_W'(start_y_reg);
            s1_px_reg    <= in_px;
            s1_py_reg    <= in_py;
            s1_clamp_reg <= s_tuser;

            s2_pvx_reg   <= s1_vx_reg * s1_dx_reg;
            s2_pvy_reg   <= s1_vy_reg * s1_dy_reg;
            s2_ddx_reg   <= s1_dx_reg * s1_dx_reg;
            s2_ddy_reg   <= s1_dy_reg * s1_dy_reg;
            s2_dx_reg    <= s1_dx_reg;
            s2_dy_reg    <= s1_dy_reg;
            s2_px_reg    <= s1_px_reg;
            s2_py_reg    <= s1_py_reg;
            s2_clamp_reg <= s1_clamp_reg;

            s3_dot_reg   <= DOT_W'(s2_pvx_reg) + DOT_W'(s2_pvy_reg);
            s3_l2_reg    <= L2_W'($unsigned(s2_ddx_reg)) + L2_W'($unsigned(s2_ddy_reg));
            s3_dx_reg    <= s2_dx_reg;
            s3_dy_reg    <= s2_dy_reg;
            s3_px_reg    <= s2_px_reg;
            s3_py_reg    <= s2_py_reg;
            s3_clamp_reg <= s2_clamp_reg;

            s4_ppx_lo_reg     <= PPLO_W'(adx) * PPLO_W'(dot_mag[17:0]);
            s4_ppy_lo_reg     <= PPLO_W'(ady) * PPLO_W'(dot_mag[17:0]);
            s4_ppx_hi_reg     <= PPHI_W'(adx) * PPHI_W'(dot_mag[DOT_W-1:18]);
            s4_ppy_hi_reg     <= PPHI_W'(ady) * PPHI_W'(dot_mag[DOT_W-1:18]);
            s4_l2_reg         <= s3_l2_reg;
            s4_side_reg.px    <= s3_px_reg;
            s4_side_reg.py    <= s3_py_reg;
            s4_side_reg.neg_x <= s3_dx_reg[DIFF_W-1] ^ dot_neg;
            s4_side_reg.neg_y <= s3_dy_reg[DIFF_W-1] ^ dot_neg;
            s4_side_reg.sel   <= sel_next;
            s4_side_reg.degen <= degen_next;

            s5_numx_reg <= (NUM_W'(s4_ppx_hi_reg) << 18) + NUM_W'(s4_ppx_lo_reg);
            s5_numy_reg <= (NUM_W'(s4_ppy_hi_reg) << 18) + NUM_W'(s4_ppy_lo_reg);
            s5_l2_reg   <= s4_l2_reg;
            s5_side_reg <= s4_side_reg;
        end
    end

    // Projection dividers: |d * dot| / l2 for each axis.
    logic [QUOT_W-1:0] quot_x, quot_y;
    side_t             side_line_reg [0:DIV_LAT-1];

    psc_proj_div u_div_x (
        .aclk (aclk),
        .en   (en),
        .num  (s5_numx_reg),
        .den  (s5_l2_reg),
        .quot (quot_x)
    );

    psc_proj_div u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  (s5_numy_reg),
        .den  (s5_l2_reg),
        .quot (quot_y)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            side_line_reg[0] <= s5_side_reg;
            for (int i = 1; i < DIV_LAT; i++) begin
                side_line_reg[i] <= side_line_reg[i-1];
            end
        end
    end

    // Stage 6: closest point with clamping and saturation.
    side_t                    div_side;
    logic signed [CAND_W-1:0] off_x, off_y, cand_x, cand_y;
    coord_t                   cx_next, cy_next;

    assign div_side = side_line_reg[DIV_LAT-1];
    assign off_x  = div_side.neg_x ? -$signed(CAND_W'(quot_x)) : $signed(CAND_W'(quot_x));
    assign off_y  = div_side.neg_y ? -$signed(CAND_W'(quot_y)) : $signed(CAND_W'(quot_y));
    assign cand_x = CAND_W'(start_x_reg) + off_x;
    assign cand_y = CAND_W'(start_y_reg) + off_y;

    always_comb begin
        case (div_side.sel)
            SEL_LINE: begin
                cx_next = sat_coord(cand_x);
                cy_next = sat_coord(cand_y);
            end
            SEL_END: begin
                cx_next = end_x_reg;
                cy_next = end_y_reg;
            end
            default: begin
                cx_next = start_x_reg;
                cy_next = start_y_reg;
            end
        endcase
    end

    tail_t                    s6_tail_reg, s7_tail_reg, s8_tail_reg, s9_tail_reg;
    coord_t                   s6_px_reg, s6_py_reg;
    diff_t                    s7_qx_reg, s7_qy_reg;
    logic signed [PROD_W-1:0] s8_sqx_reg, s8_sqy_reg;
    logic [RAD_W-1:0]         s9_rad_reg;
    tail_t                    tail_line_reg [0:SQRT_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_tail_reg.cx    <= cx_next;
            s6_tail_reg.cy    <= cy_next;
            s6_tail_reg.degen <= div_side.degen;
            s6_px_reg         <= div_side.px;
            s6_py_reg         <= div_side.py;

            s7_qx_reg   <= DIFF_W'(s6_px_reg) - DIFF_W'(s6_tail_reg.cx);
            s7_qy_reg   <= DIFF_W'(s6_py_reg) - DIFF_W'(s6_tail_reg.cy);
            s7_tail_reg <= s6_tail_reg;

            s8_sqx_reg  <= s7_qx_reg * s7_qx_reg;
            s8_sqy_reg  <= s7_qy_reg * s7_qy_reg;
            s8_tail_reg <= s7_tail_reg;

            s9_rad_reg  <= RAD_W'($unsigned(s8_sqx_reg)) + RAD_W'($unsigned(s8_sqy_reg));
            s9_tail_reg <= s8_tail_reg;

            tail_line_reg[0] <= s9_tail_reg;
            for (int i = 1; i < SQRT_LAT; i++) begin
                tail_line_reg[i] <= tail_line_reg[i-1];
            end
        end
    end

    logic [ROOT_W-1:0] dist_root;

    psc_isqrt u_dist_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (s9_rad_reg),
        .root (dist_root)
    );

    // Segment properties: these follow the registers continuously.
    diff_t               seg_dx_reg, seg_dy_reg;
    logic [SDIV_W-1:0]   unused_w;
    logic [SNUM_W-1:0]   seg_num_reg;
    logic [SDEN_W-1:0]   seg_den_reg;
    logic                seg_flat_reg, seg_neg_reg;
    logic [PROD_W-1:0]   seg_sqx_reg, seg_sqy_reg;
    logic [RAD_W-1:0]    seg_l2_reg;
    coord_t              seg_midx_reg, seg_midy_reg;
    logic [SLOPE_W-1:0]  seg_slope_reg;
    logic [SQUOT_W-1:0]  slope_quot;
    logic [ROOT_W-1:0]   seg_len;
    logic [DIFF_W-1:0]   seg_adx, seg_ady;
    diff_t               sum_x, sum_y;

    assign unused_w = '0;
    assign seg_adx  = seg_dx_reg[DIFF_W-1] ? DIFF_W'(-seg_dx_reg) : DIFF_W'(seg_dx_reg);
    assign seg_ady  = seg_dy_reg[DIFF_W-1] ? DIFF_W'(-seg_dy_reg) : DIFF_W'(seg_dy_reg);
    assign sum_x    = DIFF_W'(start_x_reg) + DIFF_W'(end_x_reg);
    assign sum_y    = DIFF_W'(start_y_reg) + DIFF_W'(end_y_reg);

    always_ff @(posedge aclk) begin
        seg_dx_reg   <= DIFF_W'(end_x_reg) - DIFF_W'(start_x_reg);
        seg_dy_reg   <= DIFF_W'(end_y_reg) - DIFF_W'(start_y_reg);
        seg_num_reg  <= {seg_ady, 16'b0};
        seg_den_reg  <= seg_adx;
        seg_flat_reg <= (seg_adx == '0) || (seg_adx < DIFF_W'(thresh_reg));
        seg_neg_reg  <= seg_dx_reg[DIFF_W-1] ^ seg_dy_reg[DIFF_W-1];
        seg_sqx_reg  <= PROD_W'(seg_dx_reg * seg_dx_reg);
        seg_sqy_reg  <= PROD_W'(seg_dy_reg * seg_dy_reg);
        seg_l2_reg   <= seg_sqx_reg + seg_sqy_reg;
        // Halve toward zero: bias negative sums by one before the shift.
        seg_midx_reg <= COORD_W'((sum_x + DIFF_W'(sum_x[DIFF_W-1])) >>> 1);
        seg_midy_reg <= COORD_W'((sum_y + DIFF_W'(sum_y[DIFF_W-1])) >>> 1);
        if (seg_flat_reg) begin
            seg_slope_reg <= '0;
        end else if (seg_neg_reg) begin
            seg_slope_reg <= (slope_quot > SQUOT_W'(33'h0_8000_0000)) ? 32'h8000_0000
                           : SLOPE_W'(-slope_quot);
        end else begin
            seg_slope_reg <= (slope_quot > SQUOT_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                           : SLOPE_W'(slope_quot);
        end
    end

    psc_slope_div u_slope_div (
        .aclk (aclk),
        .num  (seg_num_reg | SNUM_W'(unused_w)),
        .den  (seg_den_reg),
        .quot (slope_quot)
    );

    psc_isqrt u_len_sqrt (
        .aclk (aclk),
        .en   (1'b1),
        .rad  (seg_l2_reg),
        .root (seg_len)
    );

    // Output word register.
    tail_t                  out_tail;
    logic [TDATA_OUT_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;

    assign out_tail = tail_line_reg[SQRT_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            m_tdata_reg <= {6'b0, seg_len, seg_slope_reg, seg_midy_reg, seg_midx_reg,
                            dist_root, out_tail.cy, out_tail.cx};
            m_tuser_reg <= out_tail.degen;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A zero-length segment always reports the start point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[COORD_W-1:0] == start_x_reg &&
                                   m_tdata[2*COORD_W-1:COORD_W] == start_y_reg))
        else $error("degenerate result does not hold the start point");

    // Input is refused only when a result is blocked behind the output word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && vld_reg[LAST]))
        else $error("input stalled without a blocked result");

    // A blocked result stays in the last stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[LAST] && !en) |=> vld_reg[LAST])
        else $error("blocked result dropped from the last stage");

endmodule

// ===== sv/psc_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on psc_pkg for widths.
module psc_isqrt import psc_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    typedef struct packed {
        logic [SQ_WORK_W-1:0] rem;
        logic [SQ_WORK_W-1:0] root;
    } sq_state_t;

    sq_state_t st_reg [0:SQRT_LAT-1];

    // One step of the digit-by-digit method, the trial bit fixed per stage.
    function automatic sq_state_t sq_step(input sq_state_t s, input int k);
        sq_state_t            r;
        logic [SQ_WORK_W-1:0] bitv;
        logic [SQ_WORK_W-1:0] sum;
        bitv = '0;
        bitv[2 * (ROOT_W - 1 - k)] = 1'b1;
        sum = s.root + bitv;
        if (s.rem >= sum) begin
            r.rem  = s.rem - sum;
            r.root = (s.root >> 1) + bitv;
        end else begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= sq_step({SQ_WORK_W'(rad), {SQ_WORK_W{1'b0}}}, 0);
            for (int k = 1; k < SQRT_LAT; k++) begin
                st_reg[k] <= sq_step(st_reg[k-1], k);
            end
        end
    end

    assign root = st_reg[SQRT_LAT-1].root[ROOT_W-1:0];

endmodule

// ===== sv/psc_proj_div.sv =====
// Pipelined restoring divider for the projection offset, one quotient bit per stage.
// Depends on psc_pkg for widths; the quotient is known to fit QUOT_W bits.
module psc_proj_div import psc_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [L2_W-1:0]   den,
    output logic [QUOT_W-1:0] quot
);

    logic [NUM_W-1:0]  rem_reg  [0:DIV_LAT-1];
    logic [L2_W-1:0]   den_reg  [0:DIV_LAT-1];
    logic [QUOT_W-1:0] quot_reg [0:DIV_LAT-1];

    // Trial subtract of den shifted left by sh; the top bit of diff is the borrow.
    function automatic logic [NUM_W:0] trial(input logic [NUM_W-1:0] r,
                                             input logic [L2_W-1:0] d, input int sh);
        logic [NUM_W:0] dsh;
        dsh = (NUM_W+1)'(d) << sh;
        return {1'b0, r} - dsh;
    endfunction

    always_ff @(posedge aclk) begin
        logic [NUM_W:0] diff;
        if (en) begin
            diff = trial(num, den, QUOT_W - 1);
            rem_reg[0]  <= diff[NUM_W] ? num : diff[NUM_W-1:0];
            quot_reg[0] <= QUOT_W'(!diff[NUM_W]);
            den_reg[0]  <= den;
            for (int i = 1; i < DIV_LAT; i++) begin
                diff = trial(rem_reg[i-1], den_reg[i-1], QUOT_W - 1 - i);
                rem_reg[i]  <= diff[NUM_W] ? rem_reg[i-1] : diff[NUM_W-1:0];
                quot_reg[i] <= {quot_reg[i-1][QUOT_W-2:0], !diff[NUM_W]};
                den_reg[i]  <= den_reg[i-1];
            end
        end
    end

    assign quot = quot_reg[DIV_LAT-1];

endmodule

// ===== sv/psc_slope_div.sv =====
// Pipelined restoring divider for the segment slope magnitude.
// Depends on psc_pkg for widths.
module psc_slope_div import psc_pkg::*; (
    input  logic               aclk,
    input  logic [SNUM_W-1:0]  num,
    input  logic [SDEN_W-1:0]  den,
    output logic [SQUOT_W-1:0] quot
);

    logic [SNUM_W-1:0]  rem_reg  [0:SQUOT_W-1];
    logic [SDEN_W-1:0]  den_reg  [0:SQUOT_W-1];
    logic [SQUOT_W-1:0] quot_reg [0:SQUOT_W-1];

    function automatic logic [SDIV_W-1:0] trial(input logic [SNUM_W-1:0] r,
                                                input logic [SDEN_W-1:0] d, input int sh);
        logic [SDIV_W-1:0] dsh;
        dsh = SDIV_W'(d) << sh;
        return SDIV_W'(r) - dsh;
    endfunction

    always_ff @(posedge aclk) begin
        logic [SDIV_W-1:0] diff;
        diff = trial(num, den, SQUOT_W - 1);
        rem_reg[0]  <= diff[SDIV_W-1] ? num : diff[SNUM_W-1:0];
        quot_reg[0] <= SQUOT_W'(!diff[SDIV_W-1]);
        den_reg[0]  <= den;
        for (int i = 1; i < SQUOT_W; i++) begin
            diff = trial(rem_reg[i-1], den_reg[i-1], SQUOT_W - 1 - i);
            rem_reg[i]  <= diff[SDIV_W-1] ? rem_reg[i-1] : diff[SNUM_W-1:0];
            quot_reg[i] <= {quot_reg[i-1][SQUOT_W-2:0], !diff[SDIV_W-1]};
            den_reg[i]  <= den_reg[i-1];
        end
    end

    assign quot = quot_reg[SQUOT_W-1];

endmodule

// ===== test/tb_point_segment_closest_distance_top.sv =====
// Self-checking testbench for point_segment_closest_distance_top.
// Depends on psc_pkg and the block's RTL; untyped queries are predicted in place from the segment registers.
module tb_point_segment_closest_distance_top;
    import psc_pkg::*;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [16:0]        pdist;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [31:0] slope;
        logic [16:0]        len;
        logic               degen;
    } answer_t;

    typedef struct {
        int      seg;
        int      px;
        int      py;
        bit      clamp;
        bit      typed;
        answer_t ans;
    } query_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // point_x [15:0], point_y [31:16]
    logic [TDATA_IN_W-1:0]  s_tdata = '0;
    // clamp_to_segment [0]
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    // closest_x [15:0], closest_y [31:16], point_distance [48:32], mid_x [64:49],
    // mid_y [80:65], slope_value [112:81], segment_length [129:113]
    logic [TDATA_OUT_W-1:0] m_tdata;
    // degenerate [0]
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [COORD_W-1:0]     cfg_data = '0;

    // The predictor's copy of the segment registers, reset values included.
    coord_t      seg_sx = '0, seg_sy = '0, seg_ex = '0, seg_ey = '0;
    logic [15:0] seg_thresh = 16'd1;

    answer_t answer_q[$];
    bit      cur_typed = 1'b0;
    answer_t cur_ans = '0;
    bit      idle_on = 1'b1;
    bit      hold_done = 1'b0;
    int      sent = 0, received = 0, mismatches = 0, degen_seen = 0, clamp_seen = 0;

    point_segment_closest_distance_top uut (.*);

    always #4 aclk = ~aclk;

    // Truncated square root, one result bit per step from the top down.
    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned r, t;
        r = 0;
        for (int b = 17; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // Closest point on the configured segment, plus the segment's own measures.
    function automatic answer_t closest_on_segment(coord_t px, coord_t py, bit clamp);
        longint sx, sy, ex, ey, dx, dy, vx, vy, l2, dot, cx, cy, qx, qy, adx, sl;
        answer_t a;
        sx = longint'(seg_sx); sy = longint'(seg_sy);
        ex = longint'(seg_ex); ey = longint'(seg_ey);
        dx = ex - sx; dy = ey - sy;
        vx = longint'(px) - sx; vy = longint'(py) - sy;
        l2 = dx * dx + dy * dy;
        dot = vx * dx + vy * dy;
        if (l2 == 0 || (clamp && dot < 0)) begin
            cx = sx; cy = sy;
        end else if (clamp && dot > l2) begin
            cx = ex; cy = ey;
        end else begin
            cx = sx + (dx * dot) / l2;
            cy = sy + (dy * dot) / l2;
        end
        cx = clip(cx, -32768, 32767);
        cy = clip(cy, -32768, 32767);
        qx = longint'(px) - cx;
        qy = longint'(py) - cy;
        adx = (dx < 0) ? -dx : dx;
        // A vertical segment has slope zero no matter the threshold.
        if (dx == 0 || adx < longint'(seg_thresh)) sl = 0;
        else sl = clip((dy * 65536) / dx, -64'sd2147483648, 64'sd2147483647);
        a.cx = cx[15:0];
        a.cy = cy[15:0];
        a.pdist = 17'(floor_root(qx * qx + qy * qy));
        a.mx = 16'((sx + ex) / 2);
        a.my = 16'((sy + ey) / 2);
        a.slope = sl[31:0];
        a.len = 17'(floor_root(l2));
        a.degen = (l2 == 0);
        return a;
    endfunction

    // Writes a list of registers back to back, keeping cfg_valid high throughout.
    task automatic write_regs(input logic [CFG_IDX_W-1:0] idx[$], input logic [15:0] val[$]);
        foreach (idx[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (idx[i])
                REG_START_X: seg_sx = val[i];
                REG_START_Y: seg_sy = val[i];
                REG_END_X:   seg_ex = val[i];
                REG_END_Y:   seg_ey = val[i];
                REG_THRESH:  seg_thresh = val[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Drains the pipeline, loads a new segment and lets the slope and length settle.
    task automatic load_segment(int sx, int sy, int ex, int ey, int th, bit junk);
        logic [CFG_IDX_W-1:0] idx[$];
        logic [15:0]          val[$];
        s_tvalid <= 1'b0;
        wait (answer_q.size() == 0);
        repeat (50) @(posedge aclk);
        idx = '{REG_START_X, REG_START_Y, REG_END_X, REG_END_Y, REG_THRESH};
        val = '{sx[15:0], sy[15:0], ex[15:0], ey[15:0], th[15:0]};
        if (junk) begin
            // Indexes past the threshold register must leave the segment alone.
            idx.push_back(3'd5); val.push_back(16'hFFFF);
            idx.push_back(3'd6); val.push_back(16'h8000);
            idx.push_back(3'd7); val.push_back(16'h1234);
        end
        write_regs(idx, val);
        repeat (50) @(posedge aclk);
    endtask

    task automatic send_point(int px, int py, bit clamp, bit typed, answer_t ans);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {py[15:0], px[15:0]};
        s_tuser   <= clamp;
        cur_typed <= typed;
        cur_ans   <= ans;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Scoreboard: the expectation is formed when the query word is accepted and
    // compared when the matching result word is accepted.
    always @(posedge aclk) begin
        answer_t got, want;
        if (aresetn && s_tvalid && s_tready) begin
            answer_q.push_back(cur_typed ? cur_ans
                               : closest_on_segment(s_tdata[15:0], s_tdata[31:16], s_tuser));
            sent++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.cx = m_tdata[15:0];    got.cy = m_tdata[31:16];  got.pdist = m_tdata[48:32];
            got.mx = m_tdata[64:49];   got.my = m_tdata[80:65];  got.slope = m_tdata[112:81];
            got.len = m_tdata[129:113]; got.degen = m_tuser;
            received++;
            if (answer_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result word %0d arrived unexpected", received);
            end else begin
                want = answer_q.pop_front();
                if (got.degen) degen_seen++;
                if (got !== want || m_tdata[135:130] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"word %0d: exp c=(%0d,%0d) d=%0d m=(%0d,%0d) s=%0d l=%0d g=%0d",
                                  " got c=(%0d,%0d) d=%0d m=(%0d,%0d) s=%0d l=%0d g=%0d"},
                                 received, want.cx, want.cy, want.pdist, want.mx, want.my,
                                 want.slope, want.len, want.degen, got.cx, got.cy, got.pdist,
                                 got.mx, got.my, got.slope, got.len, got.degen);
                end
            end
        end
    end

    // Receiver: short random stalls, plus one long hold that backs up the pipeline.
    // The hold starts at the first result of the second random phase, while the
    // rest of that phase is still in the pipeline or still to be sent.
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!hold_done && received >= 73) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (200) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        query_row_t rows[$];
        int         segs[6][5];
        int         cur_seg, sx, sy, ex, ey, th, px, py;
        answer_t    zero_ans, a;

        // Directed segments: reset default, full diagonal, vertical, flat by
        // threshold, saturating slope, zero length away from the origin.
        segs = '{'{0, 0, 0, 0, 1}, '{-32768, -32768, 32767, 32767, 0},
                 '{100, -200, 100, 300, 0}, '{0, 0, 16, 32767, 65535},
                 '{0, -32768, 1, 32767, 1}, '{1000, -1000, 1000, -1000, 0}};
        zero_ans = '0;
        zero_ans.degen = 1'b1;
        a = zero_ans;
        rows.push_back('{0, 0, 0, 0, 1, a});
        a.pdist = 80;
        rows.push_back('{0, 48, 64, 1, 1, a});
        a.pdist = 46340;
        rows.push_back('{0, -32768, -32768, 0, 1, a});
        rows.push_back('{0, 32767, -32768, 1, 0, zero_ans});
        rows.push_back('{1, -32768, 32767, 0, 0, zero_ans});
        rows.push_back('{1, 32767, -32768, 1, 0, zero_ans});
        rows.push_back('{1, -32768, -32768, 1, 0, zero_ans});
        rows.push_back('{1, 32767, 32767, 0, 0, zero_ans});
        rows.push_back('{2, 0, -1000, 1, 0, zero_ans});
        rows.push_back('{2, 0, 1000, 1, 0, zero_ans});
        rows.push_back('{2, 0, 1000, 0, 0, zero_ans});
        rows.push_back('{2, -32768, 32767, 0, 0, zero_ans});
        rows.push_back('{3, 32767, 0, 0, 0, zero_ans});
        rows.push_back('{3, -32768, -32768, 0, 0, zero_ans});
        rows.push_back('{3, -32768, -32768, 1, 0, zero_ans});
        rows.push_back('{4, 32767, 0, 0, 0, zero_ans});
        rows.push_back('{4, -32768, 100, 1, 0, zero_ans});
        rows.push_back('{4, 0, 0, 0, 0, zero_ans});
        rows.push_back('{5, 5, 5, 0, 0, zero_ans});
        rows.push_back('{5, 5, 5, 1, 0, zero_ans});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (50) @(posedge aclk);

        cur_seg = 0;
        foreach (rows[i]) begin
            if (rows[i].seg != cur_seg) begin
                cur_seg = rows[i].seg;
                load_segment(segs[cur_seg][0], segs[cur_seg][1], segs[cur_seg][2],
                             segs[cur_seg][3], segs[cur_seg][4], cur_seg == 1);
            end
            send_point(rows[i].px, rows[i].py, rows[i].clamp, rows[i].typed, rows[i].ans);
        end

        // Random phases: each loads a fresh segment and streams points at it.
        for (int ph = 0; ph < 12; ph++) begin
            if (ph >= 10) idle_on = 1'b0;
            sx = $urandom_range(0, 65535) - 32768;
            sy = $urandom_range(0, 65535) - 32768;
            case ($urandom_range(0, 3))
                0: begin ex = sx + $urandom_range(0, 64) - 32; ey = sy + $urandom_range(0, 64) - 32; end
                1: begin ex = sx; ey = $urandom_range(0, 65535) - 32768; end
                default: begin
                    ex = $urandom_range(0, 65535) - 32768;
                    ey = $urandom_range(0, 65535) - 32768;
                end
            endcase
            ex = int'(clip(ex, -32768, 32767));
            ey = int'(clip(ey, -32768, 32767));
            case ($urandom_range(0, 3))
                0: th = 0;
                1: th = 65535;
                default: th = $urandom_range(0, 2048);
            endcase
            load_segment(sx, sy, ex, ey, th, 1'b0);
            for (int k = 0; k < 52; k++) begin
                if ($urandom_range(0, 2) == 0) begin
                    // Points close to the segment's ends, to land near the clamp edges.
                    px = int'(clip(($urandom_range(0, 1) ? sx : ex)
                                   + int'($urandom_range(0, 512)) - 256, -32768, 32767));
                    py = int'(clip(($urandom_range(0, 1) ? sy : ey)
                                   + int'($urandom_range(0, 512)) - 256, -32768, 32767));
                end else begin
                    px = $urandom_range(0, 65535) - 32768;
                    py = $urandom_range(0, 65535) - 32768;
                end
                if ($urandom_range(0, 1)) clamp_seen++;
                send_point(px, py, clamp_seen[0], 1'b0, zero_ans);
            end
        end
        s_tvalid <= 1'b0;

        wait (answer_q.size() == 0);
        repeat (60) @(posedge aclk);
        $display("Ran %0d query words over 18 segments, %0d results checked, %0d degenerate.",
                 sent, received, degen_seen);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatching result words", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== point_segment_closest_distance_top.f =====
sv/psc_pkg.sv
sv/psc_isqrt.sv
sv/psc_proj_div.sv
sv/psc_slope_div.sv
sv/point_segment_closest_distance_top.sv
test/tb_point_segment_closest_distance_top.sv
